FILE: rtl/nav_word_bch_deinterleave_decode_assert.svh
// assertion macros for the navigation word decoder
`ifndef NAV_WORD_BCH_DEINTERLEAVE_DECODE_ASSERT_SVH
`define NAV_WORD_BCH_DEINTERLEAVE_DECODE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NWBD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define NWBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define NWBD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/nwbd_pkg.sv
// shared constants and syndrome table for the navigation word decoder
package nwbd_pkg;

   localparam int unsigned WordBits   = 30;
   localparam int unsigned CodeBits   = 15;
   localparam int unsigned DataBits   = 11;
   localparam int unsigned ParityBits = CodeBits - DataBits;

   // mode codes
   localparam logic MODE_PASS   = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef logic [WordBits-1:0]   word_type;
   typedef logic [CodeBits-1:0]   code_type;
   typedef logic [ParityBits-1:0] syndrome_type;

   // x^p mod (x^4 + x + 1)
   function automatic syndrome_type syn_pow(input logic [3:0] p);
      syndrome_type v;
      unique case (p)
         4'd0:    v = 4'h1;
         4'd1:    v = 4'h2;
         4'd2:    v = 4'h4;
         4'd3:    v = 4'h8;
         4'd4:    v = 4'h3;
         4'd5:    v = 4'h6;
         4'd6:    v = 4'hC;
         4'd7:    v = 4'hB;
         4'd8:    v = 4'h5;
         4'd9:    v = 4'hA;
         4'd10:   v = 4'h7;
         4'd11:   v = 4'hE;
         4'd12:   v = 4'hF;
         4'd13:   v = 4'hD;
         4'd14:   v = 4'h9;
         default: v = 4'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/nwbd_stream_if.sv
// valid/ready channels for the navigation word decoder
interface nwbd_req_if;
   logic                valid;
   logic                ready;
   logic                mode;
   nwbd_pkg::word_type  coded_word;

   modport source (output valid, output mode, output coded_word, input ready);
   modport sink   (input valid, input mode, input coded_word, output ready);
endinterface

interface nwbd_rsp_if;
   logic                valid;
   logic                ready;
   nwbd_pkg::word_type  decoded_word;

   modport source (output valid, output decoded_word, input ready);
   modport sink   (input valid, input decoded_word, output ready);
endinterface

FILE: rtl/nav_word_bch_deinterleave_decode.sv
// top level of the navigation word deinterleaver and bch decoder
// usage:
//  - req_if carries one item per handshake: mode and a 30-bit word of hard
//    decisions, symbol i on bit i
//  - rsp_if returns one decoded 30-bit word per item, in arrival order
//  - mode pass returns the word unchanged; mode decode splits even and odd
//    symbols into two codewords, corrects each in its own lane, and packs
//    a data, b data, a parity, b parity
//  - rsp valid rises in the cycle after acceptance
//  - throughput is one item per cycle unless the receiver stalls; both lanes
//    and the merge are pure logic ahead of the single output register
//  - a stalled receiver holds the output register; outside reset req ready
//    drops only while a result is waiting and rsp ready is low
//  - synchronous reset empties the output register and holds req ready low;
//    no other state
module nav_word_bch_deinterleave_decode (
   input  logic            clock,
   input  logic            reset,
   nwbd_req_if.sink        req_if,
   nwbd_rsp_if.source      rsp_if
);

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               accept;
   logic               pass_accept;
   nwbd_pkg::code_type cw_a;
   nwbd_pkg::code_type cw_b;
   nwbd_pkg::code_type fixed_a;
   nwbd_pkg::code_type fixed_b;

   // outside reset, the output register takes a new item whenever it is empty or being drained
   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign pass_accept  = accept && (req_if.mode == nwbd_pkg::MODE_PASS);

   // deinterleave: even symbols to codeword a, odd symbols to codeword b
   always_comb begin
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         cw_a[c] = req_if.coded_word[2*c];
         cw_b[c] = req_if.coded_word[2*c+1];
      end
   end

   // two correction lanes side by side
   nwbd_bch_lane u_lane_a (
      .cw       (cw_a),
      .cw_fixed (fixed_a)
   );

   nwbd_bch_lane u_lane_b (
      .cw       (cw_b),
      .cw_fixed (fixed_b)
   );

   // merge lanes and hold the result
   nwbd_merge u_merge (
      .clock      (clock),
      .load       (accept),
      .mode       (req_if.mode),
      .coded_word (req_if.coded_word),
      .cw_a       (fixed_a),
      .cw_b       (fixed_b),
      .decoded_ff (rsp_if.decoded_word)
   );

   // result valid: set on accept, held while stalled
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

`include "nav_word_bch_deinterleave_decode_assert.svh"

   // every accepted item shows up on the output next cycle
   `NWBD_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_if.valid)
   // pass-through items leave unchanged
   `NWBD_ASSERT_NEXT(a_pass_unchanged, clock, reset, pass_accept, rsp_if.decoded_word == $past(req_if.coded_word))
   // a waiting result blocks new items
   `NWBD_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_if.valid && !rsp_if.ready, !req_if.ready)
   // reset empties the output stage
   `NWBD_ASSERT_ALWAYS_NEXT(a_reset_empties, clock, reset, !rsp_if.valid)

endmodule

FILE: rtl/nwbd_bch_lane.sv
// single-error bch(15,11) correction of one codeword
module nwbd_bch_lane (
   input  nwbd_pkg::code_type cw,
   output nwbd_pkg::code_type cw_fixed
);

   nwbd_pkg::syndrome_type syndrome;
   nwbd_pkg::code_type     flip;

   always_comb begin
      syndrome = '0;
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         if (cw[c]) begin
            syndrome = syndrome ^ nwbd_pkg::syn_pow(4'(nwbd_pkg::CodeBits - 1 - c));
         end
      end
      // bit c carries x^(14-c); flip the one whose power matches
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         flip[c] = (syndrome != '0) &&
                   (syndrome == nwbd_pkg::syn_pow(4'(nwbd_pkg::CodeBits - 1 - c)));
      end
   end

   assign cw_fixed = cw ^ flip;

endmodule

FILE: rtl/nwbd_merge.sv
// packs the corrected codewords, or the raw word in pass mode, and registers it
module nwbd_merge (
   input  logic               clock,
   input  logic               load,
   input  logic               mode,
   input  nwbd_pkg::word_type coded_word,
   input  nwbd_pkg::code_type cw_a,
   input  nwbd_pkg::code_type cw_b,
   output nwbd_pkg::word_type decoded_ff
);

   nwbd_pkg::word_type decoded_in;

   always_comb begin
      if (mode == nwbd_pkg::MODE_PASS) begin
         decoded_in = coded_word;
      end else begin
         decoded_in = {cw_b[nwbd_pkg::CodeBits-1:nwbd_pkg::DataBits],
                       cw_a[nwbd_pkg::CodeBits-1:nwbd_pkg::DataBits],
                       cw_b[nwbd_pkg::DataBits-1:0],
                       cw_a[nwbd_pkg::DataBits-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         decoded_ff <= decoded_in;
      end
   end

endmodule

FILE: tb/nav_word_bch_deinterleave_decode_checker.sv
`timescale 1ns / 1ps
// scoreboard that predicts every decoded word and checks the result channel
module nav_word_bch_deinterleave_decode_checker (
   input  logic        clock,
   input  logic        reset,
   nwbd_req_if         req_mon,
   nwbd_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   // ring of expected words, far deeper than the single output register
   localparam int unsigned Depth = 16;

   nwbd_pkg::word_type expected_words[Depth];
   int unsigned        wr_idx      = 0;
   int unsigned        rd_idx      = 0;
   int unsigned        mismatches  = 0;
   int unsigned        outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   // remainder of the codeword polynomial by x^4 + x + 1, bit 0 first (x^14)
   function automatic nwbd_pkg::syndrome_type code_remainder(input nwbd_pkg::code_type cw);
      nwbd_pkg::syndrome_type r;
      logic                   carry;
      r = '0;
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         carry = r[3];
         r     = {r[2:0], cw[c]};
         if (carry) r = r ^ 4'h3;
      end
      return r;
   endfunction

   // flip the one bit whose power of x leaves this remainder
   function automatic nwbd_pkg::code_type correct_code(input nwbd_pkg::code_type cw);
      nwbd_pkg::syndrome_type r;
      nwbd_pkg::syndrome_type pw;
      r  = code_remainder(cw);
      pw = 4'h1;
      if (r != '0) begin
         for (int p = 0; p < nwbd_pkg::CodeBits; p++) begin
            if (pw == r) begin
               cw[nwbd_pkg::CodeBits-1-p] = ~cw[nwbd_pkg::CodeBits-1-p];
               break;
            end
            pw = pw[3] ? ({pw[2:0], 1'b0} ^ 4'h3) : {pw[2:0], 1'b0};
         end
      end
      return cw;
   endfunction

   function automatic nwbd_pkg::word_type decode_nav_word(input logic mode,
                                                          input nwbd_pkg::word_type coded);
      nwbd_pkg::code_type a;
      nwbd_pkg::code_type b;
      if (mode == nwbd_pkg::MODE_PASS) return coded;
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         a[c] = coded[2*c];
         b[c] = coded[2*c+1];
      end
      a = correct_code(a);
      b = correct_code(b);
      return {b[nwbd_pkg::CodeBits-1:nwbd_pkg::DataBits], a[nwbd_pkg::CodeBits-1:nwbd_pkg::DataBits],
              b[nwbd_pkg::DataBits-1:0], a[nwbd_pkg::DataBits-1:0]};
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            if (outstanding == Depth) begin
               $error("decoded_word: expected at most %0d waiting, actual %0d",
                      Depth, outstanding + 1);
               mismatches++;
            end else begin
               expected_words[wr_idx] = decode_nav_word(req_mon.mode, req_mon.coded_word);
               wr_idx = (wr_idx + 1) % Depth;
               outstanding++;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outstanding == 0) begin
               $error("decoded_word: expected none, actual %h", rsp_mon.decoded_word);
               mismatches++;
            end else begin
               if (rsp_mon.decoded_word !== expected_words[rd_idx]) begin
                  $error("decoded_word: expected %h, actual %h",
                         expected_words[rd_idx], rsp_mon.decoded_word);
                  mismatches++;
               end
               rd_idx = (rd_idx + 1) % Depth;
               outstanding--;
            end
         end
      end
   end

endmodule

FILE: tb/nav_word_bch_deinterleave_decode_tb.sv
`timescale 1ns / 1ps
// stimulus, clocking and verdict for the navigation word decoder
module nav_word_bch_deinterleave_decode_tb;

   // random items per idling phase, four phases in all
   localparam int unsigned RandomPerPhase = 275;
   // cycles waited after the last expected result to catch any stray result
   localparam int unsigned DrainCycles    = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned fail_count;
   int unsigned pending_count;

   nwbd_req_if req_ch ();
   nwbd_rsp_if rsp_ch ();

   nav_word_bch_deinterleave_decode i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // the checker watches both channels and keeps the expected words
   nav_word_bch_deinterleave_decode_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // systematic encoder: data in bits 0-10, parity in bits 11-14 (x^3 down to x^0)
   function automatic nwbd_pkg::code_type encode_data(input logic [nwbd_pkg::DataBits-1:0] data);
      nwbd_pkg::code_type     cw;
      nwbd_pkg::syndrome_type r;
      logic                   carry;
      cw = '0;
      cw[nwbd_pkg::DataBits-1:0] = data;
      r = '0;
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         carry = r[3];
         r     = {r[2:0], cw[c]};
         if (carry) r = r ^ 4'h3;
      end
      cw[nwbd_pkg::CodeBits-1:nwbd_pkg::DataBits] = {r[0], r[1], r[2], r[3]};
      return cw;
   endfunction

   // codeword a on the even symbols, b on the odd ones
   function automatic nwbd_pkg::word_type interleave_codes(input nwbd_pkg::code_type a,
                                                           input nwbd_pkg::code_type b);
      nwbd_pkg::word_type w;
      for (int c = 0; c < nwbd_pkg::CodeBits; c++) begin
         w[2*c]   = a[c];
         w[2*c+1] = b[c];
      end
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high when the next item follows without a gap
   task automatic send_word(input logic mode, input nwbd_pkg::word_type coded);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.coded_word <= coded;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly well-formed words with zero, one or two errors, plus pure noise
   task automatic send_random_item();
      nwbd_pkg::word_type w;
      logic [31:0]        rnd_a;
      logic [31:0]        rnd_b;
      int unsigned        roll;
      int unsigned        s1;
      int unsigned        s2;
      roll  = $urandom_range(99);
      rnd_a = $urandom;
      rnd_b = $urandom;
      w = interleave_codes(encode_data(rnd_a[nwbd_pkg::DataBits-1:0]),
                           encode_data(rnd_b[nwbd_pkg::DataBits-1:0]));
      if (roll < 10) begin
         send_word(nwbd_pkg::MODE_PASS, nwbd_pkg::word_type'($urandom));
      end else if (roll < 30) begin
         send_word(nwbd_pkg::MODE_DECODE, w);
      end else if (roll < 70) begin
         // one error in one lane, and sometimes one in the other lane too
         s1 = $urandom_range(nwbd_pkg::WordBits-1);
         w[s1] = ~w[s1];
         if ($urandom_range(1) == 1) begin
            s2 = 2 * $urandom_range(nwbd_pkg::CodeBits-1) + (1 - s1 % 2);
            w[s2] = ~w[s2];
         end
         send_word(nwbd_pkg::MODE_DECODE, w);
      end else if (roll < 85) begin
         // two errors in the same lane get miscorrected silently
         s1 = $urandom_range(nwbd_pkg::WordBits-1);
         s2 = (s1 + 2 * $urandom_range(nwbd_pkg::CodeBits-1, 1)) % nwbd_pkg::WordBits;
         w[s1] = ~w[s1];
         w[s2] = ~w[s2];
         send_word(nwbd_pkg::MODE_DECODE, w);
      end else begin
         send_word(nwbd_pkg::MODE_DECODE, nwbd_pkg::word_type'($urandom));
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.mode       = nwbd_pkg::MODE_PASS;
      req_ch.coded_word = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // pass-through mode leaves any pattern alone
      send_word(nwbd_pkg::MODE_PASS, '0);
      send_word(nwbd_pkg::MODE_PASS, '1);
      send_word(nwbd_pkg::MODE_PASS, 30'h2AAAAAAA);
      send_word(nwbd_pkg::MODE_PASS, 30'h15555555);
      // clean codewords: all zeros, all ones, one lane full of data
      send_word(nwbd_pkg::MODE_DECODE, '0);
      send_word(nwbd_pkg::MODE_DECODE, '1);
      send_word(nwbd_pkg::MODE_DECODE, interleave_codes(encode_data('1), encode_data('0)));
      send_word(nwbd_pkg::MODE_DECODE,
                interleave_codes(encode_data(11'h2A5), encode_data(11'h5DA)));
      // single errors at the first and last bit of each lane, data and parity
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 0);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 1);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 28);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 29);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 20);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 21);
      send_word(nwbd_pkg::MODE_DECODE, 30'd1 << 22);
      send_word(nwbd_pkg::MODE_DECODE, '1 ^ (30'd1 << 10));
      // one error in each lane
      send_word(nwbd_pkg::MODE_DECODE, (30'd1 << 4) | (30'd1 << 9));
      // two errors in one lane: miscorrected with no flag
      send_word(nwbd_pkg::MODE_DECODE, (30'd1 << 0) | (30'd1 << 2));
      send_word(nwbd_pkg::MODE_DECODE, (30'd1 << 1) | (30'd1 << 29));

      // idling phases: none, sender gaps, receiver stalls, light on both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         repeat (RandomPerPhase) send_random_item();
      end
      req_ch.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // safety net far beyond the slowest correct run
   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/nwbd_pkg.sv
rtl/nwbd_stream_if.sv
rtl/nwbd_bch_lane.sv
rtl/nwbd_merge.sv
rtl/nav_word_bch_deinterleave_decode.sv
tb/nav_word_bch_deinterleave_decode_checker.sv
tb/nav_word_bch_deinterleave_decode_tb.sv
